@@ rtl/bsim_pkg.sv @@
// ----------------------------------------------------------------------------
// bsim_pkg
// Shared types and constants for the bank-switch and IRQ mapper: request
// and mapping structs, operation codes, register decode and reset values.
// ----------------------------------------------------------------------------
package bsim_pkg;

    // Request kind
    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_TICK  = 1'b1
    } op_t;

    // Register select taken from address bits 15..12
    localparam logic [3:0] SEL_RELOAD_NIB0 = 4'h8;
    localparam logic [3:0] SEL_RELOAD_NIB1 = 4'h9;
    localparam logic [3:0] SEL_RELOAD_NIB2 = 4'hA;
    localparam logic [3:0] SEL_RELOAD_NIB3 = 4'hB;
    localparam logic [3:0] SEL_ENABLE      = 4'hC;
    localparam logic [3:0] SEL_ACK         = 4'hD;
    localparam logic [3:0] SEL_INDEX       = 4'hE;
    localparam logic [3:0] SEL_BANK        = 4'hF;

    // Bank register index codes
    localparam logic [2:0] IDX_PRG_8000 = 3'd1;
    localparam logic [2:0] IDX_PRG_A000 = 3'd2;
    localparam logic [2:0] IDX_PRG_C000 = 3'd3;
    localparam logic [2:0] IDX_LOW_BANK = 3'd4;
    localparam logic [2:0] IDX_LOW_SEL  = 3'd5;

    // Counter terminal value
    localparam logic [15:0] COUNT_TERMINAL = 16'hFFFF;

    // Reset values of the bank registers
    localparam logic [7:0] RST_PRG_8000 = 8'd0;
    localparam logic [7:0] RST_PRG_A000 = 8'd1;
    localparam logic [7:0] RST_PRG_C000 = 8'd2;
    localparam logic [7:0] RST_LOW_BANK = 8'd3;

    // One input request
    typedef struct packed {
        op_t         op;
        logic [15:0] address;
        logic [7:0]  write_data;
    } req_t;

    // Mapping and IRQ status after a request
    typedef struct packed {
        logic [7:0] bank_8000;
        logic [7:0] bank_a000;
        logic [7:0] bank_c000;
        logic [7:0] low_bank;
        logic       low_from_rom;
        logic       irq;
    } map_t;

endpackage

@@ rtl/bsim_core.sv @@
// ----------------------------------------------------------------------------
// bsim_core
// Mapper register file and cycle counter. Applies one request per cycle
// while fire is high and presents the mapping that results from it.
// ----------------------------------------------------------------------------
module bsim_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fire,
    input  bsim_pkg::req_t req,
    output bsim_pkg::map_t view_next
);
    import bsim_pkg::*;

    logic [15:0] reload_reg,  reload_next;
    logic [15:0] count_reg,   count_next;
    logic        enable_reg,  enable_next;
    logic        irq_reg,     irq_next;
    logic [2:0]  index_reg,   index_next;
    logic [7:0]  prg0_reg,    prg0_next;
    logic [7:0]  prg1_reg,    prg1_next;
    logic [7:0]  prg2_reg,    prg2_next;
    logic [7:0]  low_bank_reg, low_bank_next;
    logic        low_sel_reg, low_sel_next;

    logic [3:0]  nib;
    logic [15:0] count_inc;

    assign nib       = req.write_data[3:0];
    assign count_inc = count_reg + 16'd1;

    // Decode the request against the current register state
    always_comb
    begin
        reload_next   = reload_reg;
        count_next    = count_reg;
        enable_next   = enable_reg;
        irq_next      = irq_reg;
        index_next    = index_reg;
        prg0_next     = prg0_reg;
        prg1_next     = prg1_reg;
        prg2_next     = prg2_reg;
        low_bank_next = low_bank_reg;
        low_sel_next  = low_sel_reg;

        if (req.op == OP_TICK)
        begin
            if (enable_reg)
            begin
                if (count_inc == COUNT_TERMINAL)
                begin
                    count_next = reload_reg;
                    irq_next   = 1'b1;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
        end
        else
        begin
            case (req.address[15:12])
                SEL_RELOAD_NIB0: reload_next[3:0]   = nib;
                SEL_RELOAD_NIB1: reload_next[7:4]   = nib;
                SEL_RELOAD_NIB2: reload_next[11:8]  = nib;
                SEL_RELOAD_NIB3: reload_next[15:12] = nib;
                SEL_ENABLE:
                begin
                    enable_next = (nib != 4'd0);
                    if (nib != 4'd0)
                    begin
                        count_next = reload_reg;
                    end
                    irq_next = 1'b0;
                end
                SEL_ACK:   irq_next   = 1'b0;
                SEL_INDEX: index_next = req.write_data[2:0];
                SEL_BANK:
                begin
                    case (index_reg)
                        IDX_PRG_8000: prg0_next     = req.write_data;
                        IDX_PRG_A000: prg1_next     = req.write_data;
                        IDX_PRG_C000: prg2_next     = req.write_data;
                        IDX_LOW_BANK: low_bank_next = req.write_data;
                        IDX_LOW_SEL:  low_sel_next  = req.write_data[2];
                        default:      ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // Advance the register state on each processed request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_reg   <= '0;
            count_reg    <= '0;
            enable_reg   <= 1'b0;
            irq_reg      <= 1'b0;
            index_reg    <= '0;
            prg0_reg     <= RST_PRG_8000;
            prg1_reg     <= RST_PRG_A000;
            prg2_reg     <= RST_PRG_C000;
            low_bank_reg <= RST_LOW_BANK;
            low_sel_reg  <= 1'b0;
        end
        else if (fire)
        begin
            reload_reg   <= reload_next;
            count_reg    <= count_next;
            enable_reg   <= enable_next;
            irq_reg      <= irq_next;
            index_reg    <= index_next;
            prg0_reg     <= prg0_next;
            prg1_reg     <= prg1_next;
            prg2_reg     <= prg2_next;
            low_bank_reg <= low_bank_next;
            low_sel_reg  <= low_sel_next;
        end
    end

    // Present the mapping as it stands after this request
    always_comb
    begin
        view_next.bank_8000    = prg0_next;
        view_next.bank_a000    = prg1_next;
        view_next.bank_c000    = prg2_next;
        view_next.low_bank     = low_sel_next ? low_bank_next : 8'd0;
        view_next.low_from_rom = low_sel_next;
        view_next.irq          = irq_next;
    end

`ifndef SYNTHESIS
    a_irq_rise_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(irq_reg) |-> $past(fire && req.op == OP_TICK))
        else $error("IRQ raised by something other than a tick");

    a_count_holds_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(count_reg))
        else $error("counter moved without a request");

    a_count_holds_disabled: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && req.op == OP_TICK && !enable_reg) |=> $stable(count_reg))
        else $error("counter moved while disabled");
`endif

endmodule

@@ rtl/bank_switch_irq_mapper.sv @@
// ----------------------------------------------------------------------------
// bank_switch_irq_mapper
// Cartridge bank-switch registers with a CPU-cycle IRQ counter: request
// register, mapper core and result register.
// ----------------------------------------------------------------------------
// Takes one request (CPU write or CPU clock tick) every cycle unless stalled and
// returns one result per request, in order. A request is held in the input
// register, where the mapper core applies it to its registers in a single
// read-modify-write; the mapping that follows is loaded into the result
// register. Results stream at one per cycle while out_stall is low. A stall
// on the result side holds the result and, once the input register is also
// full, stalls the request side.
module bank_switch_irq_mapper (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [15:0] address,
    input  logic [7:0]  write_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  bank_window_8000,
    output logic [7:0]  bank_window_a000,
    output logic [7:0]  bank_window_c000,
    output logic [7:0]  low_window_bank,
    output logic        low_window_from_rom,
    output logic        irq_line
);
    import bsim_pkg::*;

    logic  in_vld_reg, in_vld_next;
    req_t  req_reg;
    logic  out_vld_reg, out_vld_next;
    map_t  res_reg;
    map_t  view_next;
    logic  in_fire;
    logic  out_free;
    logic  stage_fire;

    // Handshake control
    assign out_free   = !out_vld_reg || !out_stall;
    assign stage_fire = in_vld_reg && out_free;
    assign in_stall   = in_vld_reg && !out_free;
    assign in_fire    = in_valid && !in_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_fire)
        begin
            in_vld_next = 1'b1;
        end
        else if (stage_fire)
        begin
            in_vld_next = 1'b0;
        end
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (stage_fire)
        begin
            out_vld_next = 1'b1;
        end
        else if (out_vld_reg && !out_stall)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Hold the accepted request
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_reg.op         <= op_t'(operation);
            req_reg.address    <= address;
            req_reg.write_data <= write_data;
        end
    end

    // Apply the request to the mapper registers
    bsim_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (stage_fire),
        .req       (req_reg),
        .view_next (view_next)
    );

    // Load the result
    always_ff @(posedge clk)
    begin
        if (stage_fire)
        begin
            res_reg <= view_next;
        end
    end

    assign out_valid           = out_vld_reg;
    assign bank_window_8000    = res_reg.bank_8000;
    assign bank_window_a000    = res_reg.bank_a000;
    assign bank_window_c000    = res_reg.bank_c000;
    assign low_window_bank     = res_reg.low_bank;
    assign low_window_from_rom = res_reg.low_from_rom;
    assign irq_line            = res_reg.irq;

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_vld_reg && out_vld_reg && out_stall))
        else $error("request stalled with room in the pipeline");

    a_result_follows_stage: assert property (@(posedge clk) disable iff (!rst_n)
        stage_fire |=> out_vld_reg)
        else $error("processed request produced no result");

    a_stage_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_fire && !in_fire) |=> !in_vld_reg)
        else $error("request register not released after processing");
`endif

endmodule

@@ tb/sv/tb_bank_switch_irq_mapper.sv @@
// ----------------------------------------------------------------------------
// tb_bank_switch_irq_mapper
// Self-checking bench for the bank-switch and IRQ mapper. A queue of CPU
// write and tick requests feeds a clocked driver. A software copy of the
// mapper registers predicts the mapping after each accepted request, and a
// clocked monitor compares every result against that prediction in order.
// Both sides idle in random bursts, and the last part of the run streams
// without gaps.
// ----------------------------------------------------------------------------
module tb_bank_switch_irq_mapper;
    import bsim_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 10;
    localparam int RANDOM_TARGET = 530;
    localparam int QUIET_TAIL = 40;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        operation = 1'b0;
    logic [15:0] address = 16'h0000;
    logic [7:0]  write_data = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  bank_window_8000;
    logic [7:0]  bank_window_a000;
    logic [7:0]  bank_window_c000;
    logic [7:0]  low_window_bank;
    logic        low_window_from_rom;
    logic        irq_line;

    // Mirror of the mapper registers
    logic [15:0] reload_word = 16'h0000;
    logic [15:0] tick_count = 16'h0000;
    logic        count_enabled = 1'b0;
    logic        irq_flag = 1'b0;
    logic [2:0]  bank_index = 3'd0;
    logic [7:0]  prg_bank [0:2] = '{RST_PRG_8000, RST_PRG_A000, RST_PRG_C000};
    logic [7:0]  low_bank_reg = RST_LOW_BANK;
    logic        low_rom_sel = 1'b0;

    req_t pending_reqs [$];
    map_t expected_maps [$];

    int mismatch_count = 0;
    int stuck_cycles = 0;
    int cycle_count = 0;
    int idle_pct = 0;
    int gap_left = 0;
    int stall_left = 0;

    bank_switch_irq_mapper dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .operation           (operation),
        .address             (address),
        .write_data          (write_data),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .bank_window_8000    (bank_window_8000),
        .bank_window_a000    (bank_window_a000),
        .bank_window_c000    (bank_window_c000),
        .low_window_bank     (low_window_bank),
        .low_window_from_rom (low_window_from_rom),
        .irq_line            (irq_line)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Apply one request to the mirrored registers and return the new mapping
    task automatic mapper_apply(input req_t r, output map_t m);
        logic [3:0] nib;
        nib = r.write_data[3:0];
        if (r.op == OP_TICK)
        begin
            if (count_enabled)
            begin
                tick_count = tick_count + 16'd1;
                if (tick_count == COUNT_TERMINAL)
                begin
                    tick_count = reload_word;
                    irq_flag = 1'b1;
                end
            end
        end
        else
        begin
            case (r.address[15:12])
                SEL_RELOAD_NIB0: reload_word[3:0] = nib;
                SEL_RELOAD_NIB1: reload_word[7:4] = nib;
                SEL_RELOAD_NIB2: reload_word[11:8] = nib;
                SEL_RELOAD_NIB3: reload_word[15:12] = nib;
                SEL_ENABLE:
                begin
                    count_enabled = (nib != 4'd0);
                    if (count_enabled)
                        tick_count = reload_word;
                    irq_flag = 1'b0;
                end
                SEL_ACK: irq_flag = 1'b0;
                SEL_INDEX: bank_index = r.write_data[2:0];
                SEL_BANK:
                begin
                    case (bank_index)
                        IDX_PRG_8000: prg_bank[0] = r.write_data;
                        IDX_PRG_A000: prg_bank[1] = r.write_data;
                        IDX_PRG_C000: prg_bank[2] = r.write_data;
                        IDX_LOW_BANK: low_bank_reg = r.write_data;
                        IDX_LOW_SEL:  low_rom_sel = r.write_data[2];
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
        m.bank_8000    = prg_bank[0];
        m.bank_a000    = prg_bank[1];
        m.bank_c000    = prg_bank[2];
        m.low_bank     = low_rom_sel ? low_bank_reg : 8'd0;
        m.low_from_rom = low_rom_sel;
        m.irq          = irq_flag;
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        mismatch_count++;
        $display("mismatch %s: got 0x%0h expected 0x%0h", what, got, want);
    endtask

    task automatic push_req(input op_t op, input logic [15:0] addr, input logic [7:0] data);
        req_t r;
        r.op = op;
        r.address = addr;
        r.write_data = data;
        pending_reqs.push_back(r);
    endtask

    // Drive requests: hold while stalled, predict on accept, then idle or advance
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        req_t cur;
        req_t nxt;
        map_t m;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            operation <= 1'b0;
            address <= 16'h0000;
            write_data <= 8'h00;
            gap_left <= 0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (in_valid)
            begin
                cur.op = op_t'(operation);
                cur.address = address;
                cur.write_data = write_data;
                mapper_apply(cur, m);
                expected_maps.push_back(m);
            end
            if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_reqs.size() >= QUIET_TAIL && $urandom_range(0, 99) < idle_pct)
            begin
                gap_left <= $urandom_range(0, 10);
                in_valid <= 1'b0;
            end
            else if (pending_reqs.size() != 0)
            begin
                nxt = pending_reqs.pop_front();
                in_valid <= 1'b1;
                operation <= nxt.op;
                address <= nxt.address;
                write_data <= nxt.write_data;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Check each accepted result against the oldest prediction, then pick stall
    always @(posedge clk or negedge rst_n)
    begin : check_proc
        map_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_maps.size() == 0)
                    report_mismatch("result with nothing expected", 16'h0, 16'h0);
                else
                begin
                    want = expected_maps.pop_front();
                    if (bank_window_8000 !== want.bank_8000)
                        report_mismatch("bank_window_8000", 16'(bank_window_8000),
                                        16'(want.bank_8000));
                    if (bank_window_a000 !== want.bank_a000)
                        report_mismatch("bank_window_a000", 16'(bank_window_a000),
                                        16'(want.bank_a000));
                    if (bank_window_c000 !== want.bank_c000)
                        report_mismatch("bank_window_c000", 16'(bank_window_c000),
                                        16'(want.bank_c000));
                    if (low_window_bank !== want.low_bank)
                        report_mismatch("low_window_bank", 16'(low_window_bank),
                                        16'(want.low_bank));
                    if (low_window_from_rom !== want.low_from_rom)
                        report_mismatch("low_window_from_rom", 16'(low_window_from_rom),
                                        16'(want.low_from_rom));
                    if (irq_line !== want.irq)
                        report_mismatch("irq_line", 16'(irq_line), 16'(want.irq));
                end
            end
            if (pending_reqs.size() < QUIET_TAIL)
                out_stall <= 1'b0;
            else if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                out_stall <= 1'b1;
            end
            else if ($urandom_range(0, 99) < idle_pct)
            begin
                stall_left <= $urandom_range(0, 10);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Count cycles without progress and vary the idle density over time
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            if (cycle_count % 64 == 0)
            begin
                case ($urandom_range(0, 3))
                    0: idle_pct <= 0;
                    1: idle_pct <= 8;
                    2: idle_pct <= 25;
                    default: idle_pct <= 50;
                endcase
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STALL_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Build the request list, release reset, and wait for the run to drain
    initial
    begin : stim_proc
        int k;
        int n;
        logic [3:0] nib;
        // Directed: ignored writes, tick while disabled, every bank index
        push_req(OP_WRITE, 16'h0000, 8'hFF);
        push_req(OP_WRITE, 16'h7FFF, 8'hAA);
        push_req(OP_TICK,  16'hFFFF, 8'hFF);
        push_req(OP_WRITE, {SEL_INDEX, 12'hFFF}, 8'hF9);
        push_req(OP_WRITE, {SEL_BANK, 12'h000}, 8'hFF);
        push_req(OP_WRITE, {SEL_INDEX, 12'h000}, {5'd0, IDX_PRG_A000});
        push_req(OP_WRITE, {SEL_BANK, 12'hFFF}, 8'h80);
        push_req(OP_WRITE, {SEL_INDEX, 12'h000}, {5'd0, IDX_PRG_C000});
        push_req(OP_WRITE, {SEL_BANK, 12'h123}, 8'h7F);
        push_req(OP_WRITE, {SEL_INDEX, 12'h000}, {5'd0, IDX_LOW_BANK});
        push_req(OP_WRITE, {SEL_BANK, 12'h000}, 8'hC5);
        push_req(OP_WRITE, {SEL_INDEX, 12'h000}, {5'b11111, IDX_LOW_SEL});
        push_req(OP_WRITE, {SEL_BANK, 12'h000}, 8'h04);
        push_req(OP_WRITE, {SEL_INDEX, 12'h000}, 8'h00);
        push_req(OP_WRITE, {SEL_BANK, 12'h000}, 8'h55);
        push_req(OP_WRITE, {SEL_INDEX, 12'h000}, 8'h06);
        push_req(OP_WRITE, {SEL_BANK, 12'h000}, 8'h66);
        push_req(OP_WRITE, {SEL_INDEX, 12'h000}, 8'h07);
        push_req(OP_WRITE, {SEL_BANK, 12'h000}, 8'h77);
        // Directed: reload 0xFFFE, enable, IRQ on every tick, ack, disable
        push_req(OP_WRITE, {SEL_RELOAD_NIB0, 12'hFFF}, 8'hFE);
        push_req(OP_WRITE, {SEL_RELOAD_NIB1, 12'h000}, 8'hFF);
        push_req(OP_WRITE, {SEL_RELOAD_NIB2, 12'h123}, 8'h0F);
        push_req(OP_WRITE, {SEL_RELOAD_NIB3, 12'h000}, 8'hFF);
        push_req(OP_WRITE, {SEL_ENABLE, 12'h000}, 8'h01);
        push_req(OP_TICK,  16'h0000, 8'h00);
        push_req(OP_WRITE, {SEL_ACK, 12'hFFF}, 8'h00);
        push_req(OP_TICK,  16'h0000, 8'h00);
        push_req(OP_WRITE, {SEL_ENABLE, 12'h000}, 8'hF0);
        push_req(OP_TICK,  16'h1234, 8'h5A);

        // Random: mostly well-formed register sequences, some noise
        while (pending_reqs.size() < RANDOM_TARGET)
        begin
            k = $urandom_range(0, 99);
            if (k < 30)
            begin
                n = $urandom_range(1, 10);
                repeat (n)
                    push_req(OP_TICK, 16'($urandom), 8'($urandom));
            end
            else if (k < 45)
            begin
                // reload near the terminal value so the IRQ fires often
                push_req(OP_WRITE, {SEL_RELOAD_NIB0, 12'($urandom)}, 8'($urandom));
                nib = ($urandom_range(0, 4) != 0) ? 4'hF : 4'($urandom);
                push_req(OP_WRITE, {SEL_RELOAD_NIB1, 12'($urandom)}, {4'($urandom), nib});
                nib = ($urandom_range(0, 4) != 0) ? 4'hF : 4'($urandom);
                push_req(OP_WRITE, {SEL_RELOAD_NIB2, 12'($urandom)}, {4'($urandom), nib});
                nib = ($urandom_range(0, 4) != 0) ? 4'hF : 4'($urandom);
                push_req(OP_WRITE, {SEL_RELOAD_NIB3, 12'($urandom)}, {4'($urandom), nib});
                if ($urandom_range(0, 9) < 7)
                    push_req(OP_WRITE, {SEL_ENABLE, 12'($urandom)},
                             {4'($urandom), 4'($urandom_range(1, 15))});
            end
            else if (k < 55)
            begin
                nib = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(1, 15)) : 4'h0;
                push_req(OP_WRITE, {SEL_ENABLE, 12'($urandom)}, {4'($urandom), nib});
            end
            else if (k < 62)
                push_req(OP_WRITE, {SEL_ACK, 12'($urandom)}, 8'($urandom));
            else if (k < 80)
            begin
                push_req(OP_WRITE, {SEL_INDEX, 12'($urandom)}, 8'($urandom));
                push_req(OP_WRITE, {SEL_BANK, 12'($urandom)}, 8'($urandom));
            end
            else if (k < 88)
                push_req(OP_WRITE, {($urandom_range(0, 1) != 0) ? SEL_INDEX : SEL_BANK,
                                    12'($urandom)}, 8'($urandom));
            else
                push_req(op_t'($urandom_range(0, 1)), 16'($urandom), 8'($urandom));
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: all requests accepted, all results checked, then a short tail
        while (pending_reqs.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_maps.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ files.f @@
rtl/bsim_pkg.sv
rtl/bsim_core.sv
rtl/bank_switch_irq_mapper.sv
tb/sv/tb_bank_switch_irq_mapper.sv
